[design/stbs_pkg.sv]
package stbs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int RANGE_W     = $clog2(TABLE_DEPTH + 1);

  // Word field widths
  localparam int KEY_W   = 32;
  localparam int INDEX_W = 10;
  localparam int POS_W   = 10;
  localparam int COUNT_W = 11;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_ENTRY_COUNT = 1'b0;

  // Word modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PROBE = 3'b010,
    ST_DONE  = 3'b100
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic write_en;
    logic start;
    logic step;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic hit;
    logic range_done;
    logic out_busy;
  } status_t;

endpackage

[design/stbs_ram.sv]
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, hold when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/stbs_ctrl.sv]
module stbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_stall,
  input  stbs_pkg::status_t status,
  output stbs_pkg::cmd_t    cmd
);

  stbs_pkg::state_t state_r, state_nxt;

  // Sequence one word at a time
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state_r)
      stbs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_mode == stbs_pkg::MODE_WRITE) begin
            cmd.write_en = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = status.empty ? stbs_pkg::ST_DONE : stbs_pkg::ST_PROBE;
          end
        end
      end
      stbs_pkg::ST_PROBE: begin
        cmd.step = 1'b1;
        if (status.hit || status.range_done) begin
          state_nxt = stbs_pkg::ST_DONE;
        end
      end
      stbs_pkg::ST_DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = stbs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/stbs_dp.sv]
module stbs_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  stbs_pkg::cmd_t                       cmd,
  output stbs_pkg::status_t                    status,
  input  logic [stbs_pkg::RANGE_W-1:0]         count,
  input  logic [stbs_pkg::INDEX_W-1:0]         in_entry_index,
  input  logic signed [stbs_pkg::KEY_W-1:0]    in_key_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_found,
  output logic [stbs_pkg::POS_W-1:0]           out_position
);

  logic signed [stbs_pkg::KEY_W-1:0] key_r;
  logic signed [stbs_pkg::KEY_W-1:0] entry;
  logic [stbs_pkg::RANGE_W-1:0]      low_r, low_nxt;
  logic [stbs_pkg::RANGE_W-1:0]      hx_r, hx_nxt;
  logic [stbs_pkg::ADDR_W-1:0]       mid_r, mid0, mid_nxt;
  logic [stbs_pkg::RANGE_W:0]        sum0, sum_nxt;
  logic                              res_found_r;
  logic [stbs_pkg::POS_W-1:0]        res_pos_r;
  logic                              out_valid_r;
  logic                              out_found_r;
  logic [stbs_pkg::POS_W-1:0]        out_pos_r;
  logic                              hit, key_gt, range_done;
  logic                              ram_we, ram_re;
  logic [stbs_pkg::ADDR_W-1:0]       ram_raddr;
  logic [stbs_pkg::KEY_W-1:0]        ram_rdata;

  // First probe over the whole range [0, count)
  assign sum0 = (stbs_pkg::RANGE_W+1)'(count) - 1'b1;
  assign mid0 = stbs_pkg::ADDR_W'(sum0 >> 1);

  // Compare the probed entry and narrow the range
  assign entry  = $signed(ram_rdata);
  assign hit    = (key_r == entry);
  assign key_gt = (key_r > entry);

  always_comb begin
    low_nxt = low_r;
    hx_nxt  = hx_r;
    if (key_gt) begin
      low_nxt = stbs_pkg::RANGE_W'(mid_r) + 1'b1;
    end else begin
      hx_nxt = stbs_pkg::RANGE_W'(mid_r);
    end
  end

  assign range_done = (low_nxt >= hx_nxt);
  assign sum_nxt    = (stbs_pkg::RANGE_W+1)'(low_nxt) + (stbs_pkg::RANGE_W+1)'(hx_nxt) - 1'b1;
  assign mid_nxt    = stbs_pkg::ADDR_W'(sum_nxt >> 1);

  // Table memory port control
  assign ram_we    = cmd.write_en &&
                     (32'(in_entry_index) < 32'(stbs_pkg::TABLE_DEPTH));
  assign ram_re    = cmd.start || (cmd.step && !hit && !range_done);
  assign ram_raddr = cmd.start ? mid0 : mid_nxt;

  stbs_ram #(
    .WIDTH (stbs_pkg::KEY_W),
    .DEPTH (stbs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stbs_pkg::ADDR_W'(in_entry_index)),
    .wdata (in_key_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Search range, key and pending result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r       <= in_key_value;
      low_r       <= '0;
      hx_r        <= count;
      mid_r       <= mid0;
      res_found_r <= 1'b0;
      res_pos_r   <= '0;
    end else if (cmd.step) begin
      if (hit) begin
        res_found_r <= 1'b1;
        res_pos_r   <= stbs_pkg::POS_W'(mid_r);
      end else begin
        low_r <= low_nxt;
        hx_r  <= hx_nxt;
        mid_r <= mid_nxt;
      end
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_found_r <= res_found_r;
      out_pos_r   <= res_pos_r;
    end
  end

  assign status.empty      = (count == '0);
  assign status.hit        = hit;
  assign status.range_done = range_done;
  assign status.out_busy   = out_valid_r && out_stall;

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

endmodule

[design/sorted_table_binary_search.sv]
// Sorted-table binary search.
// Input channel (in_valid / in_stall): each word carries in_mode, in_entry_index
// and in_key_value. A write word (mode 0) stores the key at entry_index and
// gives no result. A search word (mode 1) probes the first entry_count
// entries of the table and gives one result word on the output channel
// (out_valid / out_stall) with out_found and out_position (0 if missed).
// A search probes the table memory, whose read data is registered, once per
// step of the range and then hands the result to the output register. One word
// is worked on at a time; the next word is accepted in the same cycle that the
// result first sits in the output register, and write words go at one a cycle
// while the block is idle. A result waiting on out_stall does not hold back the
// next word unless a second result finishes before the first is taken.
// Configuration: entry_count is written over the APB-style port at address 0;
// write it only while the block is idle. Values above the table depth count
// as the full table.
// Reset (rst_n low, synchronous) clears entry_count, the controller and the
// output valid; table contents are undefined until written.
module sorted_table_binary_search (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_mode,
  input  logic [stbs_pkg::INDEX_W-1:0]         in_entry_index,
  input  logic signed [stbs_pkg::KEY_W-1:0]    in_key_value,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_found,
  output logic [stbs_pkg::POS_W-1:0]           out_position,
  // Configuration port
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [stbs_pkg::PADDR_W-1:0]         cfg_paddr,
  input  logic [stbs_pkg::PDATA_W-1:0]         cfg_pwdata,
  output logic [stbs_pkg::PDATA_W-1:0]         cfg_prdata,
  output logic                                 cfg_pready
);

  logic [stbs_pkg::COUNT_W-1:0] entry_count_r;
  logic [stbs_pkg::RANGE_W-1:0] count;
  logic                         reg_sel;
  stbs_pkg::cmd_t               cmd;
  stbs_pkg::status_t            status;

  // Register decode: one word-aligned register
  assign reg_sel    = (cfg_paddr[stbs_pkg::PADDR_W-1] == stbs_pkg::REG_ENTRY_COUNT);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      entry_count_r <= stbs_pkg::COUNT_W'(cfg_pwdata);
    end
  end

  assign cfg_prdata = reg_sel ? stbs_pkg::PDATA_W'(entry_count_r) : '0;

  // Clamp the count to the table depth
  assign count = (32'(entry_count_r) > 32'(stbs_pkg::TABLE_DEPTH)) ?
                 stbs_pkg::RANGE_W'(stbs_pkg::TABLE_DEPTH) :
                 stbs_pkg::RANGE_W'(entry_count_r);

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  stbs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .count          (count),
    .in_entry_index (in_entry_index),
    .in_key_value   (in_key_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_position   (out_position)
  );

endmodule
